[rtl/cab_pkg.sv]
// ----------------------------------------------------------------------------
// cab_pkg
// shared types, constants and saturating helpers for the clover add-back
// event builder
// ----------------------------------------------------------------------------
package cab_pkg;

    // field widths
    localparam int CLOVER_W = 3;
    localparam int ENERGY_W = 16;
    localparam int RATIO_W  = 16;
    localparam int WINDOW_W = 20;
    localparam int STAMP_W  = 48;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W = 2;

    // entries that a 3-bit clover number can address
    localparam int STORE_MAX = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RATIO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RATIO = 2'd3;

    // configuration reset values
    localparam logic [ENERGY_W-1:0] THRESHOLD_RST  = 16'd0;
    localparam logic [WINDOW_W-1:0] WINDOW_RST     = 20'd100;
    localparam logic [RATIO_W-1:0]  LOW_RATIO_RST  = 16'd0;
    localparam logic [RATIO_W-1:0]  HIGH_RATIO_RST = 16'hFFFF;

    localparam logic [SUM_W-1:0]   SUM_MAX   = 24'hFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // input word kinds
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE,
        ST_WALK_RD,
        ST_WALK_EMIT,
        ST_TOTAL
    } cab_state_t;

    // one per-clover sum entry
    typedef struct packed {
        logic [SUM_W-1:0]   energy;
        logic [STAMP_W-1:0] stamp;
        logic [COUNT_W-1:0] count;
    } cab_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic rd_walk;
        logic walk_clr;
        logic walk_inc;
        logic update;
        logic emit_entry;
        logic emit_total;
    } cab_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_flush;
        logic keep;
        logic gap_close;
        logic open;
        logic entry_valid;
        logic walk_last;
        logic out_free;
    } cab_stat_t;

    function automatic logic [SUM_W-1:0] sat_add_e(input logic [SUM_W-1:0] a,
                                                   input logic [ENERGY_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc_c(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
    endfunction

endpackage

[rtl/cab_ctrl.sv]
// ----------------------------------------------------------------------------
// cab_ctrl
// sequencer: evaluates each input word, updates the sums and walks the
// clover store when a subevent closes
// ----------------------------------------------------------------------------
module cab_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cab_pkg::cab_stat_t stat,
    output cab_pkg::cab_cmd_t  cmd
);

    cab_pkg::cab_state_t state_reg;
    cab_pkg::cab_state_t state_next;
    logic                pending_reg;
    logic                pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cab_pkg::ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        in_ready     = 1'b0;

        unique case (state_reg)
            cab_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = cab_pkg::ST_EVAL;
                end
            end

            cab_pkg::ST_EVAL:
            begin
                // read port addresses the hit's clover here
                if (stat.is_flush)
                begin
                    if (stat.open)
                    begin
                        cmd.walk_clr = 1'b1;
                        pending_next = 1'b0;
                        state_next   = cab_pkg::ST_WALK_RD;
                    end
                    else
                    begin
                        state_next = cab_pkg::ST_IDLE;
                    end
                end
                else if (!stat.keep)
                begin
                    state_next = cab_pkg::ST_IDLE;
                end
                else if (stat.gap_close)
                begin
                    cmd.walk_clr = 1'b1;
                    pending_next = 1'b1;
                    state_next   = cab_pkg::ST_WALK_RD;
                end
                else
                begin
                    state_next = cab_pkg::ST_UPDATE;
                end
            end

            cab_pkg::ST_UPDATE:
            begin
                cmd.update  = 1'b1;
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                state_next  = in_valid ? cab_pkg::ST_EVAL : cab_pkg::ST_IDLE;
            end

            cab_pkg::ST_WALK_RD:
            begin
                cmd.rd_walk = 1'b1;
                if (stat.entry_valid)
                begin
                    state_next = cab_pkg::ST_WALK_EMIT;
                end
                else if (stat.walk_last)
                begin
                    state_next = cab_pkg::ST_TOTAL;
                end
                else
                begin
                    cmd.walk_inc = 1'b1;
                end
            end

            cab_pkg::ST_WALK_EMIT:
            begin
                cmd.rd_walk = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit_entry = 1'b1;
                    if (stat.walk_last)
                    begin
                        state_next = cab_pkg::ST_TOTAL;
                    end
                    else
                    begin
                        cmd.walk_inc = 1'b1;
                        state_next   = cab_pkg::ST_WALK_RD;
                    end
                end
            end

            cab_pkg::ST_TOTAL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_total = 1'b1;
                    pending_next   = 1'b0;
                    state_next     = pending_reg ? cab_pkg::ST_UPDATE : cab_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cab_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/cab_datapath.sv]
// ----------------------------------------------------------------------------
// cab_datapath
// hit filter, gap check, clover sum store, totals and output register
// ----------------------------------------------------------------------------
module cab_datapath #(
    parameter int NUM_CLOVERS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_valid,
    input  logic [cab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cab_pkg::WINDOW_W-1:0]     cfg_data,
    // input word
    input  logic                             kind,
    input  logic [cab_pkg::CLOVER_W-1:0]     clover,
    input  logic [cab_pkg::ENERGY_W-1:0]     cal_energy,
    input  logic [cab_pkg::ENERGY_W-1:0]     raw_high,
    input  logic [cab_pkg::ENERGY_W-1:0]     raw_low,
    input  logic                             low_present,
    input  logic                             saturated,
    input  logic                             pileup,
    input  logic [cab_pkg::STAMP_W-1:0]      stamp,
    // control
    input  cab_pkg::cab_cmd_t                cmd,
    output cab_pkg::cab_stat_t               stat,
    // result word
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cab_pkg::CLOVER_W-1:0]     entry_index,
    output logic                             is_total,
    output logic [cab_pkg::SUM_W-1:0]        energy_sum,
    output logic [cab_pkg::STAMP_W-1:0]      last_time,
    output logic [cab_pkg::COUNT_W-1:0]      hit_count,
    output logic                             last_of_run
);

    localparam int DEPTH = (NUM_CLOVERS < cab_pkg::STORE_MAX) ? NUM_CLOVERS
                                                              : cab_pkg::STORE_MAX;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [cab_pkg::ENERGY_W-1:0] threshold_reg;
    logic [cab_pkg::WINDOW_W-1:0] window_reg;
    logic [cab_pkg::RATIO_W-1:0]  low_ratio_reg;
    logic [cab_pkg::RATIO_W-1:0]  high_ratio_reg;

    // captured input word
    logic                         kind_reg;
    logic [cab_pkg::CLOVER_W-1:0] clover_reg;
    logic [cab_pkg::ENERGY_W-1:0] cal_energy_reg;
    logic [cab_pkg::ENERGY_W-1:0] raw_high_reg;
    logic [cab_pkg::ENERGY_W-1:0] raw_low_reg;
    logic                         low_present_reg;
    logic                         saturated_reg;
    logic                         pileup_reg;
    logic [cab_pkg::STAMP_W-1:0]  stamp_reg;

    // subevent state
    cab_pkg::cab_entry_t          mem [DEPTH];
    cab_pkg::cab_entry_t          rd_data_reg;
    logic [DEPTH-1:0]             valid_reg;
    logic [cab_pkg::SUM_W-1:0]    total_energy_reg;
    logic [cab_pkg::STAMP_W-1:0]  total_stamp_reg;
    logic [cab_pkg::COUNT_W-1:0]  total_count_reg;
    logic [cab_pkg::STAMP_W-1:0]  ref_stamp_reg;
    logic                         open_reg;
    logic [IDX_W-1:0]             walk_idx_reg;

    // output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [cab_pkg::CLOVER_W-1:0] entry_index_reg;
    logic                         is_total_reg;
    logic [cab_pkg::SUM_W-1:0]    energy_sum_reg;
    logic [cab_pkg::STAMP_W-1:0]  last_time_reg;
    logic [cab_pkg::COUNT_W-1:0]  hit_count_reg;
    logic                         last_of_run_reg;

    // combinational
    logic [IDX_W-1:0]             clv_idx;
    logic [IDX_W-1:0]             rd_addr;
    logic [23:0]                  ratio_num;
    logic [31:0]                  low_prod;
    logic [31:0]                  high_prod;
    logic                         ratio_ok;
    logic                         range_ok;
    logic [cab_pkg::STAMP_W-1:0]  gap;
    cab_pkg::cab_entry_t          cur_entry;
    cab_pkg::cab_entry_t          wr_entry;
    logic                         out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= cab_pkg::THRESHOLD_RST;
            window_reg     <= cab_pkg::WINDOW_RST;
            low_ratio_reg  <= cab_pkg::LOW_RATIO_RST;
            high_ratio_reg <= cab_pkg::HIGH_RATIO_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cab_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data[cab_pkg::ENERGY_W-1:0];
                cab_pkg::CFG_WINDOW:     window_reg     <= cfg_data;
                cab_pkg::CFG_LOW_RATIO:  low_ratio_reg  <= cfg_data[cab_pkg::RATIO_W-1:0];
                cab_pkg::CFG_HIGH_RATIO: high_ratio_reg <= cfg_data[cab_pkg::RATIO_W-1:0];
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg        <= kind;
            clover_reg      <= clover;
            cal_energy_reg  <= cal_energy;
            raw_high_reg    <= raw_high;
            raw_low_reg     <= raw_low;
            low_present_reg <= low_present;
            saturated_reg   <= saturated;
            pileup_reg      <= pileup;
            stamp_reg       <= stamp;
        end
    end

    // hit filter: ratio by cross-multiplication, threshold, clover range
    assign ratio_num = {raw_high_reg, 8'h00};
    assign low_prod  = 32'(low_ratio_reg) * 32'(raw_low_reg);
    assign high_prod = 32'(high_ratio_reg) * 32'(raw_low_reg);
    assign ratio_ok  = !low_present_reg
                       || ((32'(ratio_num) >= low_prod) && (32'(ratio_num) <= high_prod));
    assign range_ok  = (4'(clover_reg) < 4'(DEPTH));

    // absolute gap to the last kept hit
    assign gap = (stamp_reg >= ref_stamp_reg) ? (stamp_reg - ref_stamp_reg)
                                              : (ref_stamp_reg - stamp_reg);

    assign clv_idx = clover_reg[IDX_W-1:0];
    assign rd_addr = cmd.rd_walk ? walk_idx_reg : clv_idx;

    // clover store, registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.update)
        begin
            mem[clv_idx] <= wr_entry;
        end
    end

    // an entry without its valid bit reads as zero
    assign cur_entry = valid_reg[clv_idx] ? rd_data_reg : '0;

    always_comb
    begin
        wr_entry.energy = cab_pkg::sat_add_e(cur_entry.energy, cal_energy_reg);
        wr_entry.stamp  = stamp_reg;
        wr_entry.count  = cab_pkg::sat_inc_c(cur_entry.count);
    end

    // sums, valid bits, reference stamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            total_energy_reg <= '0;
            total_stamp_reg  <= '0;
            total_count_reg  <= '0;
            ref_stamp_reg    <= '0;
            open_reg         <= 1'b0;
        end
        else if (cmd.emit_total)
        begin
            valid_reg        <= '0;
            total_energy_reg <= '0;
            total_stamp_reg  <= '0;
            total_count_reg  <= '0;
            open_reg         <= 1'b0;
        end
        else if (cmd.update)
        begin
            valid_reg[clv_idx] <= 1'b1;
            total_energy_reg   <= cab_pkg::sat_add_e(total_energy_reg, cal_energy_reg);
            total_stamp_reg    <= stamp_reg;
            total_count_reg    <= cab_pkg::sat_inc_c(total_count_reg);
            ref_stamp_reg      <= stamp_reg;
            open_reg           <= 1'b1;
        end
    end

    // walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_idx_reg <= '0;
        end
        else if (cmd.walk_clr)
        begin
            walk_idx_reg <= '0;
        end
        else if (cmd.walk_inc)
        begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.emit_entry || cmd.emit_total)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_entry)
        begin
            entry_index_reg <= cab_pkg::CLOVER_W'(walk_idx_reg);
            is_total_reg    <= 1'b0;
            energy_sum_reg  <= rd_data_reg.energy;
            last_time_reg   <= rd_data_reg.stamp;
            hit_count_reg   <= rd_data_reg.count;
            last_of_run_reg <= 1'b0;
        end
        else if (cmd.emit_total)
        begin
            entry_index_reg <= '0;
            is_total_reg    <= 1'b1;
            energy_sum_reg  <= total_energy_reg;
            last_time_reg   <= total_stamp_reg;
            hit_count_reg   <= total_count_reg;
            last_of_run_reg <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = entry_index_reg;
    assign is_total    = is_total_reg;
    assign energy_sum  = energy_sum_reg;
    assign last_time   = last_time_reg;
    assign hit_count   = hit_count_reg;
    assign last_of_run = last_of_run_reg;

    // status
    always_comb
    begin
        stat.is_flush    = (kind_reg == cab_pkg::KIND_FLUSH);
        stat.keep        = !saturated_reg && !pileup_reg && ratio_ok
                           && (cal_energy_reg >= threshold_reg) && range_ok;
        stat.gap_close   = open_reg && (gap > cab_pkg::STAMP_W'(window_reg));
        stat.open        = open_reg;
        stat.entry_valid = valid_reg[walk_idx_reg];
        stat.walk_last   = (walk_idx_reg == IDX_W'(DEPTH - 1));
        stat.out_free    = out_free;
    end

`ifndef SYNTHESIS
    a_last_is_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_of_run_reg == is_total_reg))
        else $error("last_of_run and is_total disagree");

    a_entry_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_total_reg) |-> (hit_count_reg != 8'd0))
        else $error("clover word with zero hits");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_total |=> (!open_reg && (valid_reg == '0) && (total_count_reg == 8'd0)))
        else $error("sums not cleared after total");

    a_update_opens: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (open_reg && (total_count_reg != 8'd0)))
        else $error("kept hit left no open subevent");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.update && (cmd.emit_entry || cmd.emit_total)))
        else $error("store update during a walk");
`endif

endmodule

[rtl/clover_addback_event_builder.sv]
// ----------------------------------------------------------------------------
// clover_addback_event_builder
// groups time-ordered germanium hits into subevents and emits per-clover
// and total add-back sums when a subevent closes.
// in channel (in_valid/in_ready): one word per hit or flush; hits are
// filtered on flags, gain ratio and threshold. cfg channel: register index
// and data, written by the user only when idle; cfg_ready is always high.
// out channel (out_valid/out_ready): one word per clover with hits, then
// the total with last_of_run set.
// a kept hit is evaluated, then added to the store; the next word is taken
// in the update state. a hit that closes the subevent is added after the
// walk. on close the walk reads every clover through the single registered
// read port of the clover store and emits a word for each clover with hits,
// then the total. a stalled receiver holds the walk, and with it the input,
// until the output register empties. reset clears all sums and opens no
// subevent.
// ----------------------------------------------------------------------------
module clover_addback_event_builder #(
    parameter int NUM_CLOVERS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cab_pkg::WINDOW_W-1:0]  cfg_data,
    // input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [cab_pkg::CLOVER_W-1:0]  clover,
    input  logic [cab_pkg::ENERGY_W-1:0]  cal_energy,
    input  logic [cab_pkg::ENERGY_W-1:0]  raw_high,
    input  logic [cab_pkg::ENERGY_W-1:0]  raw_low,
    input  logic                          low_present,
    input  logic                          saturated,
    input  logic                          pileup,
    input  logic [cab_pkg::STAMP_W-1:0]   stamp,
    // result words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cab_pkg::CLOVER_W-1:0]  entry_index,
    output logic                          is_total,
    output logic [cab_pkg::SUM_W-1:0]     energy_sum,
    output logic [cab_pkg::STAMP_W-1:0]   last_time,
    output logic [cab_pkg::COUNT_W-1:0]   hit_count,
    output logic                          last_of_run
);

    cab_pkg::cab_cmd_t  cmd;
    cab_pkg::cab_stat_t stat;
    logic               cfg_wr;

    // the user must change registers only while idle; writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // sequencer: evaluate, update, walk the store on close
    cab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // filter, sums and output register
    cab_datapath #(
        .NUM_CLOVERS (NUM_CLOVERS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_wr),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .clover      (clover),
        .cal_energy  (cal_energy),
        .raw_high    (raw_high),
        .raw_low     (raw_low),
        .low_present (low_present),
        .saturated   (saturated),
        .pileup      (pileup),
        .stamp       (stamp),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_index (entry_index),
        .is_total    (is_total),
        .energy_sum  (energy_sum),
        .last_time   (last_time),
        .hit_count   (hit_count),
        .last_of_run (last_of_run)
    );

endmodule
